[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mxp_pkg.sv]
// ---------------------------------------------------------------------------
// mxp_pkg
// Constants and types for the modular exponentiation core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mxp_pkg;

    localparam int EXP_BITS = 32;
    localparam int E_W      = (EXP_BITS > 30) ? EXP_BITS : 30;
    localparam int VAL_W    = 30;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int RW       = PROD_W + 1;
    localparam int RED_CELLS = VAL_W + 1;

    localparam logic [VAL_W-1:0] MOD     = VAL_W'(1000000007);
    localparam logic [VAL_W-1:0] INV_EXP = VAL_W'(1000000005);
    localparam logic [RW-1:0]    MOD_HI  = RW'({MOD, {VAL_W{1'b0}}});
    localparam logic [63:0]      EXP_MASK =
        (EXP_BITS >= 64) ? {64{1'b1}} : ((64'd1 << EXP_BITS) - 64'd1);

    localparam logic DST_SQ  = 1'b0;
    localparam logic DST_ACC = 1'b1;

    typedef struct packed {
        logic          valid;
        logic          dst;
        logic [RW-1:0] rem;
    } t_cell;

endpackage

[hdl/modular_exponentiation_core.sv]
// ---------------------------------------------------------------------------
// modular_exponentiation_core
// base ** exponent mod 1000000007, or the Fermat inverse, square-and-multiply.
// ---------------------------------------------------------------------------
// One request at a time. Each exponent bit up to the highest set bit issues a
// square, and a set bit also a multiply, to one shared modular multiplier
// (product register plus 31 reduction cells). Both products are waited for
// before the next bit. Inverse mode uses the 30-bit exponent 1000000005 with
// 15 set bits. A zero exponent skips the multiplier and goes straight to the
// output register. A finished result may wait in the output register while
// the next request is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modular_exponentiation_core
    import mxp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // base[29:0], exponent[61:30], zero pad
    input  logic        i_s_tuser,  // action: 0 power, 1 inverse
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata   // result[29:0], zero pad
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_MUL  = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [E_W-1:0]   r_e, n_e;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic [VAL_W-1:0] r_sq, n_sq;
    logic [1:0]       r_pend, n_pend;
    logic             r_ov, n_ov;
    logic [VAL_W-1:0] r_out, n_out;

    logic             w_iss, w_iss_dst;
    logic [VAL_W-1:0] w_a;
    logic             w_rv, w_rdst;
    logic [VAL_W-1:0] w_res;
    logic [VAL_W-1:0] w_base, w_base_red;
    logic [63:0]      w_e64;
    logic [E_W-1:0]   w_e_load;

    assign w_base     = i_s_tdata[29:0];
    assign w_base_red = (w_base >= MOD) ? (w_base - MOD) : w_base;
    assign w_e64      = 64'(i_s_tdata[61:30]) & EXP_MASK;
    assign w_e_load   = i_s_tuser ? E_W'(INV_EXP) : E_W'(w_e64);

    assign o_s_tready = (r_state == S_IDLE);

    mxp_mulred u_mulred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_iss),
        .i_dst   (w_iss_dst),
        .i_a     (w_a),
        .i_b     (r_sq),
        .o_valid (w_rv),
        .o_dst   (w_rdst),
        .o_res   (w_res)
    );

    always_comb begin
        n_state   = r_state;
        n_e       = r_e;
        n_acc     = r_acc;
        n_sq      = r_sq;
        n_ov      = r_ov;
        n_out     = r_out;
        w_iss     = 1'b0;
        w_iss_dst = DST_SQ;
        w_a       = r_sq;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end
        if (w_rv) begin
            if (w_rdst == DST_ACC) begin
                n_acc = w_res;
            end else begin
                n_sq = w_res;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_acc   = VAL_W'(1);
                    n_sq    = w_base_red;
                    n_e     = w_e_load;
                    n_state = (w_e_load == '0) ? S_DONE : S_SQ;
                end
            end
            S_SQ: begin
                w_iss   = 1'b1;
                n_state = r_e[0] ? S_MUL : S_WAIT;
            end
            S_MUL: begin
                w_iss     = 1'b1;
                w_iss_dst = DST_ACC;
                w_a       = r_acc;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (r_pend == 2'd0) begin
                    n_e     = r_e >> 1;
                    n_state = ((r_e >> 1) == '0) ? S_DONE : S_SQ;
                end
            end
            S_DONE: begin
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_out   = r_acc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_pend = r_pend + 2'(w_iss) - 2'(w_rv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 2'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
        r_e   <= n_e;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = 32'(r_out);

    `ASSERT_CLK(a_pend_max, i_clk, i_rst_n, r_pend != 2'd3, "more than two products in flight")
    `ASSERT_CLK(a_ret_pend, i_clk, i_rst_n, w_rv |-> (r_pend != 2'd0), "product returned unrequested")
    `ASSERT_CLK(a_out_range, i_clk, i_rst_n, r_ov |-> (r_out < MOD), "result not reduced")

endmodule

[hdl/mxp_cell.sv]
// ---------------------------------------------------------------------------
// mxp_cell
// One restoring reduction step: conditional subtract of MOD << 30, shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxp_cell
    import mxp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_d,
    output t_cell o_d
);

    t_cell         r_d;
    logic [RW-1:0] n_rem;

    always_comb begin
        n_rem = (i_d.rem >= MOD_HI) ? (i_d.rem - MOD_HI) : i_d.rem;
        n_rem = {n_rem[RW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else begin
            r_d.valid <= i_d.valid;
        end
        r_d.dst <= i_d.dst;
        r_d.rem <= n_rem;
    end

    assign o_d = r_d;

endmodule

[hdl/mxp_mulred.sv]
// ---------------------------------------------------------------------------
// mxp_mulred
// Modular multiplier: one product stage followed by a row of reduction cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxp_mulred
    import mxp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_dst,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_valid,
    output logic             o_dst,
    output logic [VAL_W-1:0] o_res
);

    t_cell w_chain [RED_CELLS+1];
    t_cell r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
        end else begin
            r_prod.valid <= i_valid;
        end
        r_prod.dst <= i_dst;
        r_prod.rem <= RW'(PROD_W'(i_a) * PROD_W'(i_b));
    end

    assign w_chain[0] = r_prod;

    for (genvar g = 0; g < RED_CELLS; g++) begin : g_cell
        mxp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_chain[g]),
            .o_d     (w_chain[g+1])
        );
    end

    assign o_valid = w_chain[RED_CELLS].valid;
    assign o_dst   = w_chain[RED_CELLS].dst;
    assign o_res   = w_chain[RED_CELLS].rem[RW-1 -: VAL_W];

endmodule

[tb/tb_modular_exponentiation_core.sv]
// ---------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking testbench for the modular exponentiation core. Requests are
// driven on the input stream, a behavioral square-and-multiply predictor
// computes the expected residue, and a scoreboard checks each result in order
// under varying idle and backpressure patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modular_exponentiation_core;
    import mxp_pkg::*;

    localparam longint unsigned PRIME = 64'd1000000007;
    localparam int N_RANDOM = 1330;
    localparam longint LIMIT = 64'd10000000;

    typedef enum logic {OP_POWER = 1'b0, OP_INVERSE = 1'b1} t_op;

    class residue_scoreboard;
        logic [29:0] pending_q[$];
        int errors;

        function logic [29:0] pow_mod(logic [29:0] b, logic [63:0] e);
            longint unsigned acc;
            longint unsigned sq;
            acc = 1;
            sq = b % PRIME;
            while (e != 0) begin
                if (e[0]) acc = (acc * sq) % PRIME;
                sq = (sq * sq) % PRIME;
                e = e >> 1;
            end
            return acc[29:0];
        endfunction

        function void note_request(t_op op, logic [29:0] b, logic [31:0] e);
            logic [63:0] ee;
            ee = (op == OP_INVERSE) ? 64'(INV_EXP) : (64'(e) & EXP_MASK);
            pending_q.push_back(pow_mod(b, ee));
        endfunction

        function void check_result(logic [31:0] data);
            logic [29:0] want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %0d", $time, data[29:0]);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (data[29:0] !== want || data[31:30] !== 2'b00) begin
                $display("%0t: result mismatch expected %0d actual %0d",
                         $time, want, data);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    longint cycles = 0;

    residue_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    modular_exponentiation_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(t_op op, logic [29:0] b, logic [31:0] e);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, e, b};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_request(op, b, e);
    endtask

    task automatic send_random();
        logic [29:0] b;
        logic [31:0] e;
        t_op op;
        int k;
        op = t_op'($urandom_range(3) == 0);
        k = $urandom_range(9);
        b = (k == 0) ? 30'($urandom_range(3)) :
            (k == 1) ? 30'(1000000007 + $urandom_range(73741816)) : 30'($urandom);
        k = $urandom_range(9);
        e = (k < 4) ? 32'($urandom_range(255)) : (k == 4) ? 32'(0) : $urandom;
        send_request(op, b, e);
    endtask

    initial begin
        int ph;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_POWER, 30'd0, 32'd0);
        send_request(OP_POWER, 30'd5, 32'd0);
        send_request(OP_POWER, 30'h3FFFFFFF, 32'hFFFFFFFF);
        send_request(OP_POWER, 30'd0, 32'hFFFFFFFF);
        send_request(OP_POWER, 30'd1000000007, 32'd0);
        send_request(OP_POWER, 30'd1000000007, 32'd3);
        send_request(OP_POWER, 30'd1000000006, 32'd2);
        send_request(OP_POWER, 30'd2, 32'h80000000);
        send_request(OP_POWER, 30'd3, 32'd1);
        send_request(OP_POWER, 30'h2AAAAAAA, 32'h55555555);
        send_request(OP_POWER, 30'h15555555, 32'hAAAAAAAA);
        send_request(OP_INVERSE, 30'd0, 32'd0);
        send_request(OP_INVERSE, 30'd1000000007, 32'd7);
        send_request(OP_INVERSE, 30'd1, 32'hFFFFFFFF);
        send_request(OP_INVERSE, 30'd2, 32'd0);
        send_request(OP_INVERSE, 30'h3FFFFFFF, 32'h12345678);
        send_request(OP_INVERSE, 30'd1000000006, 32'd1);

        hold_off <= 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            repeat (6) send_random();
        join

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                3: begin send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (N_RANDOM / 5) send_random();
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
